@@ hdl/pid_dm_pkg.sv @@
// Shared widths, configuration codes and stage record types of the PID derivative unit.
package pid_dm_pkg;

  // Field widths and fixed-point scaling.
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int GAIN_W    = 16;
  localparam int INTEG_W   = 31;
  localparam int OFFSET_W  = 15;
  localparam int DRIVE_W   = 16;

  // Derived arithmetic widths.
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int ACC_W     = ((INTEG_W > DIFF_W) ? INTEG_W : DIFF_W) + 1;
  localparam int PROD_PD_W = GAIN_W + DIFF_W;
  localparam int PROD_I_W  = GAIN_W + INTEG_W;
  localparam int SUM_W     = ((PROD_I_W > PROD_PD_W) ? PROD_I_W : PROD_PD_W) + 3;

  // Bus widths.
  localparam int IN_DATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DRIVE_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = INTEG_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_INTEG_UPPER,
    CFG_INTEG_LOWER,
    CFG_DRIVE_OFFSET,
    CFG_DRIVE_UPPER,
    CFG_DRIVE_LOWER
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic signed [INTEG_W-1:0]   integ_t;
  typedef logic signed [DRIVE_W-1:0]   drive_t;
  typedef logic        [OFFSET_W-1:0]  offset_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [PROD_PD_W-1:0] prod_pd_t;
  typedef logic signed [PROD_I_W-1:0]  prod_i_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  // Current configuration register contents.
  typedef struct packed {
    gain_t   gain_p;
    gain_t   gain_i;
    gain_t   gain_d;
    integ_t  integ_upper;
    integ_t  integ_lower;
    offset_t drive_offset;
    drive_t  drive_upper;
    drive_t  drive_lower;
  } cfg_t;

  // Operands handed from the integrator stage to the multiplier stage.
  typedef struct packed {
    logic   clear;
    diff_t  err;
    integ_t integ;
    diff_t  dmeas;
  } operand_t;

  // Products handed from the multiplier stage to the output stage.
  typedef struct packed {
    logic     clear;
    prod_pd_t prod_p;
    prod_i_t  prod_i;
    prod_pd_t prod_d;
  } product_t;

endpackage

@@ hdl/pid_derivative_on_measurement_unit.sv @@
// Top level of the fixed-point positional PID unit with derivative on measurement.
//
//   Channel  Direction  Handshake           Contents
//   in_      slave      in_tvalid/tready    tdata: setpoint, measured; tuser: op (clear)
//   out_     master     out_tvalid/tready   tdata: drive; tuser: drive_saturated
//   cfg_     slave      cfg_valid/ready     cfg_index, cfg_data (register write)
//
// One item is taken per cycle while the output does not stall. The pace is set by the
// integrator stage, whose accumulate and clamp feed its state register. Reset is synchronous
// and clears the pipeline, the integral and the last sample; the registers take their reset
// values. A stalled output holds every stage; a stage with a free slot keeps taking items.
module pid_derivative_on_measurement_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pid_dm_pkg::IN_DATA_W-1:0]  in_tdata,  // setpoint, measured
  input  logic                              in_tuser,  // op
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pid_dm_pkg::OUT_DATA_W-1:0] out_tdata, // drive
  output logic                              out_tuser, // drive_saturated
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pid_dm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pid_dm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pid_dm_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     v1_r, v1_nxt;
  logic     v2_r, v2_nxt;
  logic     v3_r, v3_nxt;
  logic     v4_r, v4_nxt;
  logic     rdy1, rdy2, rdy3, rdy4;
  logic     op_r;
  sample_t  sp_r;
  sample_t  ms_r;
  operand_t opnd;
  product_t prod;
  drive_t   drive;
  logic     sat;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:       cfg_nxt.gain_p       = cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       cfg_nxt.gain_i       = cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       cfg_nxt.gain_d       = cfg_data[GAIN_W-1:0];
        CFG_INTEG_UPPER:  cfg_nxt.integ_upper  = cfg_data[INTEG_W-1:0];
        CFG_INTEG_LOWER:  cfg_nxt.integ_lower  = cfg_data[INTEG_W-1:0];
        CFG_DRIVE_OFFSET: cfg_nxt.drive_offset = cfg_data[OFFSET_W-1:0];
        CFG_DRIVE_UPPER:  cfg_nxt.drive_upper  = cfg_data[DRIVE_W-1:0];
        CFG_DRIVE_LOWER:  cfg_nxt.drive_lower  = cfg_data[DRIVE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= '0;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.integ_upper  <= '0;
      cfg_r.integ_lower  <= '0;
      cfg_r.drive_offset <= '0;
      cfg_r.drive_upper  <= {1'b0, {(DRIVE_W-1){1'b1}}};
      cfg_r.drive_lower  <= {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage occupancy: each stage moves on when the one after it has room.
  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign v1_nxt = rdy1 ? in_tvalid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_tvalid && rdy1) begin
      op_r <= in_tuser;
      sp_r <= in_tdata[SAMPLE_W-1:0];
      ms_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // Integrator stage; the state moves only when an item leaves the input register.
  pid_dm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (v1_r && rdy2),
    .op       (op_r),
    .setpoint (sp_r),
    .measured (ms_r),
    .cfg      (cfg_r),
    .opnd_r   (opnd)
  );

  // Multiplier stage.
  pid_dm_mult u_mult (
    .clk    (clk),
    .load   (v2_r && rdy3),
    .opnd   (opnd),
    .cfg    (cfg_r),
    .prod_r (prod)
  );

  // Output stage.
  pid_dm_out u_out (
    .clk     (clk),
    .load    (v3_r && rdy4),
    .prod    (prod),
    .cfg     (cfg_r),
    .drive_r (drive),
    .sat_r   (sat)
  );

  assign in_tready  = rdy1;
  assign out_tvalid = v4_r;
  assign out_tdata  = OUT_DATA_W'($unsigned(drive));
  assign out_tuser  = sat;

endmodule

@@ hdl/pid_dm_front.sv @@
// Error, clamped integral and measurement difference stage with the controller state.
module pid_dm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                op,
  input  pid_dm_pkg::sample_t setpoint,
  input  pid_dm_pkg::sample_t measured,
  input  pid_dm_pkg::cfg_t    cfg,
  output pid_dm_pkg::operand_t opnd_r
);
  import pid_dm_pkg::*;

  integ_t   integ_r, integ_nxt;
  sample_t  last_meas_r, last_meas_nxt;
  diff_t    err;
  diff_t    dmeas;
  acc_t     acc;
  acc_t     acc_clamped;
  operand_t opnd_nxt;

  // Error and derivative on measurement.
  assign err   = diff_t'(setpoint) - diff_t'(measured);
  assign dmeas = diff_t'(measured) - diff_t'(last_meas_r);
  assign acc   = acc_t'(integ_r) + acc_t'(err);

  // Accumulate and clamp; the lower bound is applied last so it wins when bounds cross.
  always_comb begin
    acc_clamped = acc;
    if (acc_clamped > acc_t'(cfg.integ_upper)) begin
      acc_clamped = acc_t'(cfg.integ_upper);
    end
    if (acc_clamped < acc_t'(cfg.integ_lower)) begin
      acc_clamped = acc_t'(cfg.integ_lower);
    end

    if (op) begin
      integ_nxt     = '0;
      last_meas_nxt = '0;
    end else begin
      integ_nxt     = (cfg.gain_i != '0) ? INTEG_W'(acc_clamped) : '0;
      last_meas_nxt = measured;
    end

    opnd_nxt.clear = op;
    opnd_nxt.err   = err;
    opnd_nxt.integ = integ_nxt;
    opnd_nxt.dmeas = dmeas;
  end

  // Controller state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      last_meas_r <= '0;
    end else if (load) begin
      integ_r     <= integ_nxt;
      last_meas_r <= last_meas_nxt;
    end
  end

  // Operand register.
  always_ff @(posedge clk) begin
    if (load) begin
      opnd_r <= opnd_nxt;
    end
  end

endmodule

@@ hdl/pid_dm_mult.sv @@
// Multiplier stage forming the three gain products.
module pid_dm_mult (
  input  logic                 clk,
  input  logic                 load,
  input  pid_dm_pkg::operand_t opnd,
  input  pid_dm_pkg::cfg_t     cfg,
  output pid_dm_pkg::product_t prod_r
);
  import pid_dm_pkg::*;

  product_t prod_nxt;

  // Three independent signed products.
  always_comb begin
    prod_nxt.clear  = opnd.clear;
    prod_nxt.prod_p = prod_pd_t'(cfg.gain_p) * prod_pd_t'(opnd.err);
    prod_nxt.prod_i = prod_i_t'(cfg.gain_i) * prod_i_t'(opnd.integ);
    prod_nxt.prod_d = prod_pd_t'(cfg.gain_d) * prod_pd_t'(opnd.dmeas);
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ hdl/pid_dm_out.sv @@
// Output stage: scaled sum, dead-zone offset and drive saturation.
module pid_dm_out (
  input  logic                 clk,
  input  logic                 load,
  input  pid_dm_pkg::product_t prod,
  input  pid_dm_pkg::cfg_t     cfg,
  output pid_dm_pkg::drive_t   drive_r,
  output logic                 sat_r
);
  import pid_dm_pkg::*;

  sum_t   sum;
  sum_t   sum_off;
  sum_t   sum_sat;
  logic   sat;
  drive_t drive_nxt;
  logic   sat_nxt;

  // Each product is scaled with a flooring shift before the wide sum.
  assign sum = (sum_t'(prod.prod_p) >>> FRAC_BITS)
             + (sum_t'(prod.prod_i) >>> FRAC_BITS)
             - (sum_t'(prod.prod_d) >>> FRAC_BITS);

  // Offset away from zero, then upper and lower limits, the lower one last.
  always_comb begin
    if (sum > sum_t'(0)) begin
      sum_off = sum + sum_t'(cfg.drive_offset);
    end else if (sum < sum_t'(0)) begin
      sum_off = sum - sum_t'(cfg.drive_offset);
    end else begin
      sum_off = sum;
    end

    sum_sat = sum_off;
    sat     = 1'b0;
    if (sum_sat > sum_t'(cfg.drive_upper)) begin
      sum_sat = sum_t'(cfg.drive_upper);
      sat     = 1'b1;
    end
    if (sum_sat < sum_t'(cfg.drive_lower)) begin
      sum_sat = sum_t'(cfg.drive_lower);
      sat     = 1'b1;
    end

    if (prod.clear) begin
      drive_nxt = '0;
      sat_nxt   = 1'b0;
    end else begin
      drive_nxt = DRIVE_W'(sum_sat);
      sat_nxt   = sat;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

@@ hdl/pid_dm_checker.sv @@
// Port-level checks for the PID derivative unit and their binding to the top level.
module pid_dm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pid_dm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              cfg_ready
);

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // With the output slot empty the pipeline has room for a new transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // Leaving reset, no result is presented.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result present straight after reset");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk)
    rst_n |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind pid_derivative_on_measurement_unit pid_dm_checker u_pid_dm_checker (.*);

@@ sim/tb_pid_derivative_on_measurement_unit.sv @@
// Self-checking testbench of the PID unit with derivative on measurement.
module tb_pid_derivative_on_measurement_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_dm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_PAUSE    = 8;
  localparam int MAX_PRINTED    = 40;

  // Register contents right after reset.
  localparam cfg_t RESET_CFG = '{
    gain_p: '0, gain_i: '0, gain_d: '0,
    integ_upper: '0, integ_lower: '0, drive_offset: '0,
    drive_upper: 16'sh7FFF, drive_lower: 16'sh8000
  };

  // One expected result of the unit.
  typedef struct {
    drive_t drive;
    logic   saturated;
  } drive_result_t;

  typedef enum {RX_ALWAYS, RX_PATTERN} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // setpoint, measured
  logic                  in_tuser   = 1'b0; // op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // drive
  logic                  out_tuser;         // drive_saturated
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index  = CFG_GAIN_P;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Controller state and registers as the unit should hold them.
  cfg_t          model_cfg      = RESET_CFG;
  longint        integral_state = 0;
  longint        prev_measured  = 0;
  drive_result_t expected_drives[$];

  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  bit        tx_gaps_on     = 1'b1;
  int        burst_left     = 0;
  rx_mode_t  rx_mode        = RX_PATTERN;
  int        hold_requests  = 0;
  int        holds_served   = 0;
  int        hold_left      = 0;
  logic [15:0] rx_pattern   = '1;
  int        rx_phase       = 0;
  sample_t   loop_target    = '0;
  sample_t   loop_measured  = '0;

  pid_derivative_on_measurement_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the drive for one sample and advances the controller state.
  function automatic drive_result_t predict_drive(input logic op, input sample_t sp,
                                                  input sample_t ms);
    drive_result_t r;
    longint gp, gi, gd, iu, il, du, dl, ofs, err, acc, sum;
    r.drive     = '0;
    r.saturated = 1'b0;
    if (op) begin
      integral_state = 0;
      prev_measured  = 0;
      return r;
    end
    gp  = longint'($signed(model_cfg.gain_p));
    gi  = longint'($signed(model_cfg.gain_i));
    gd  = longint'($signed(model_cfg.gain_d));
    iu  = longint'($signed(model_cfg.integ_upper));
    il  = longint'($signed(model_cfg.integ_lower));
    du  = longint'($signed(model_cfg.drive_upper));
    dl  = longint'($signed(model_cfg.drive_lower));
    ofs = longint'(model_cfg.drive_offset);
    err = longint'(sp) - longint'(ms);
    // The integral is clamped to the upper bound first and the lower bound last.
    if (gi != 0) begin
      acc = integral_state + err;
      if (acc > iu) acc = iu;
      if (acc < il) acc = il;
      integral_state = acc;
    end else begin
      integral_state = 0;
    end
    sum = ((gp * err) >>> FRAC_BITS) + ((gi * integral_state) >>> FRAC_BITS)
        - ((gd * (longint'(ms) - prev_measured)) >>> FRAC_BITS);
    // Dead-zone offset pushes a nonzero drive away from zero.
    if (sum > 0) sum = sum + ofs;
    else if (sum < 0) sum = sum - ofs;
    if (sum > du) begin
      sum = du;
      r.saturated = 1'b1;
    end
    if (sum < dl) begin
      sum = dl;
      r.saturated = 1'b1;
    end
    prev_measured = longint'(ms);
    r.drive = sum[DRIVE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one item, with a random gap at the start of each burst.
  task automatic send_sample(input logic op, input sample_t sp, input sample_t ms);
    int gap;
    if (burst_left == 0) begin
      gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ms, sp};
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_drives.push_back(predict_drive(op, sp, ms));
    burst_left--;
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Writes all eight registers; the unused upper data bits carry junk.
  task automatic apply_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk, value;
    cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx  = cfg_idx_t'(i);
      junk = CFG_DATA_W'($urandom);
      case (idx)
        CFG_GAIN_P:       value = {junk[CFG_DATA_W-1:GAIN_W], c.gain_p};
        CFG_GAIN_I:       value = {junk[CFG_DATA_W-1:GAIN_W], c.gain_i};
        CFG_GAIN_D:       value = {junk[CFG_DATA_W-1:GAIN_W], c.gain_d};
        CFG_INTEG_UPPER:  value = c.integ_upper;
        CFG_INTEG_LOWER:  value = c.integ_lower;
        CFG_DRIVE_OFFSET: value = {junk[CFG_DATA_W-1:OFFSET_W], c.drive_offset};
        CFG_DRIVE_UPPER:  value = {junk[CFG_DATA_W-1:DRIVE_W], c.drive_upper};
        default:          value = {junk[CFG_DATA_W-1:DRIVE_W], c.drive_lower};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    model_cfg = c;
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      3:       return gain_t'($urandom);
      default: return gain_t'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  // Mostly a measurement that tracks a slowly moving setpoint, some noise and corners.
  task automatic send_random_items(input int count);
    logic    op;
    sample_t sp, ms;
    sample_t corners [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 39) == 0);
      if ($urandom_range(0, 99) == 0) loop_target = sample_t'($urandom_range(0, 4000) - 2000);
      case ($urandom_range(0, 5))
        0: begin
          sp = sample_t'($urandom);
          ms = sample_t'($urandom);
        end
        1: begin
          sp = corners[$urandom_range(0, 3)];
          ms = corners[$urandom_range(0, 3)];
        end
        default: begin
          loop_measured = loop_measured + ((loop_target - loop_measured) >>> 3)
                        + sample_t'($urandom_range(0, 16) - 8);
          sp = loop_target;
          ms = loop_measured;
        end
      endcase
      if (op) loop_measured = '0;
      send_sample(op, sp, ms);
    end
  endtask

  task automatic test_reset_state();
    // All gains are zero after reset, so every step drives zero.
    send_sample(1'b0, 16'sh7FFF, 16'sh8000);
    send_sample(1'b0, 16'sh8000, 16'sh7FFF);
    send_sample(1'b1, 16'sh1234, 16'sh4321);
    send_sample(1'b0, 16'sh0000, 16'sh0000);
    wait_drained();
  endtask

  task automatic test_gain_extremes();
    cfg_t c;
    c = RESET_CFG;
    c.gain_p      = 16'sh7FFF;
    c.gain_i      = 16'sh8000;
    c.gain_d      = 16'sh7FFF;
    c.integ_upper = 31'sh3FFFFFFF;
    c.integ_lower = 31'sh40000000;
    apply_config(c);
    send_sample(1'b0, 16'sh7FFF, 16'sh8000);
    send_sample(1'b0, 16'sh8000, 16'sh7FFF);
    send_sample(1'b0, 16'sh0000, 16'sh0000);
    send_sample(1'b0, 16'sd100, -16'sd100);
    send_sample(1'b1, 16'sh7FFF, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000, 16'sh8000);
    wait_drained();
    // Opposite gain signs with the largest offset.
    c.gain_p       = 16'sh8000;
    c.gain_i       = 16'sh7FFF;
    c.gain_d       = 16'sh8000;
    c.drive_offset = 15'h7FFF;
    apply_config(c);
    send_sample(1'b0, -16'sd1, 16'sd0);
    send_sample(1'b0, 16'sd1, 16'sd0);
    send_sample(1'b0, 16'sd0, 16'sd0);
    wait_drained();
    // Small gains keep the drive inside its limits.
    c.gain_p       = 16'sd256;
    c.gain_i       = 16'sd16;
    c.gain_d       = 16'sd128;
    c.drive_offset = 15'd5;
    c.integ_upper  = 31'sd1000;
    c.integ_lower  = -31'sd1000;
    c.drive_upper  = 16'sd1000;
    c.drive_lower  = -16'sd1000;
    apply_config(c);
    send_sample(1'b0, 16'sd10, 16'sd3);
    send_sample(1'b0, 16'sd3, 16'sd10);
    send_sample(1'b0, -16'sd5, -16'sd5);
    wait_drained();
  endtask

  task automatic test_crossed_bounds();
    cfg_t c;
    // Crossed integral bounds leave the integral at the lower bound.
    c = RESET_CFG;
    c.gain_i      = 16'sd256;
    c.integ_upper = -31'sd100;
    c.integ_lower = 31'sd100;
    apply_config(c);
    send_sample(1'b0, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sd50, 16'sd0);
    wait_drained();
    // Crossed drive bounds leave the drive at the lower limit, flagged.
    c.drive_upper = -16'sd50;
    c.drive_lower = 16'sd50;
    apply_config(c);
    send_sample(1'b0, 16'sd0, 16'sd0);
    send_sample(1'b0, -16'sd300, 16'sd200);
    wait_drained();
  endtask

  task automatic test_zero_sum();
    cfg_t c;
    // A zero sum gets no offset but is still held to the limits.
    c = RESET_CFG;
    c.gain_p       = 16'sd256;
    c.drive_offset = 15'd300;
    c.drive_upper  = -16'sd10;
    c.drive_lower  = -16'sd20;
    apply_config(c);
    send_sample(1'b0, 16'sd7, 16'sd7);
    wait_drained();
    c.drive_upper = 16'sd20;
    c.drive_lower = 16'sd10;
    apply_config(c);
    send_sample(1'b0, 16'sd7, 16'sd7);
    send_sample(1'b0, 16'sd8, 16'sd7);
    wait_drained();
  endtask

  task automatic test_random_phases(input int phases, input int items_per_phase);
    cfg_t c;
    int   m;
    for (int p = 0; p < phases; p++) begin
      c.gain_p = pick_gain();
      c.gain_i = pick_gain();
      c.gain_d = pick_gain();
      case ($urandom_range(0, 5))
        0: begin
          c.integ_upper = 31'sh3FFFFFFF;
          c.integ_lower = 31'sh40000000;
        end
        1: begin
          c.integ_upper = integ_t'(-int'($urandom_range(0, 5000)));
          c.integ_lower = integ_t'($urandom_range(1, 5000));
        end
        2: begin
          c.integ_upper = '0;
          c.integ_lower = '0;
        end
        default: begin
          m = $urandom_range(4, 30);
          c.integ_upper = integ_t'($urandom_range(0, (1 << m) - 1));
          c.integ_lower = integ_t'(-int'($urandom_range(0, 1 << m)));
        end
      endcase
      case ($urandom_range(0, 3))
        0:       c.drive_offset = '0;
        1:       c.drive_offset = 15'h7FFF;
        2:       c.drive_offset = offset_t'($urandom);
        default: c.drive_offset = offset_t'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 4))
        0: begin
          c.drive_upper = 16'sh7FFF;
          c.drive_lower = 16'sh8000;
        end
        1: begin
          c.drive_upper = drive_t'(-int'($urandom_range(0, 500)));
          c.drive_lower = drive_t'($urandom_range(1, 500));
        end
        2: begin
          c.drive_upper = drive_t'($urandom);
          c.drive_lower = drive_t'($urandom);
        end
        default: begin
          c.drive_upper = drive_t'($urandom_range(0, 32767));
          c.drive_lower = drive_t'(-int'($urandom_range(0, 32768)));
        end
      endcase
      apply_config(c);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_mode    = ($urandom_range(0, 3) == 0) ? RX_ALWAYS : RX_PATTERN;
      burst_left = 0;
      send_random_items(items_per_phase);
      wait_drained();
    end
  endtask

  task automatic test_output_hold();
    // The receiver holds off while items keep coming, so the pipeline backs up.
    tx_gaps_on = 1'b0;
    rx_mode    = RX_PATTERN;
    hold_requests <= hold_requests + 1;
    send_random_items(60);
    wait_drained();
  endtask

  task automatic test_full_rate();
    // Back-to-back transfers on both sides.
    tx_gaps_on = 1'b0;
    rx_mode    = RX_ALWAYS;
    burst_left = 0;
    send_random_items(200);
    wait_drained();
  endtask

  // Receiver readiness: a long hold on request, else always ready or a rotating pattern.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_mode == RX_ALWAYS) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= rx_pattern[rx_phase % 16];
      if (rx_phase == 63) begin
        rx_phase <= 0;
        case ($urandom_range(0, 3))
          0:       rx_pattern <= '1;
          1:       rx_pattern <= 16'($urandom);
          2:       rx_pattern <= 16'($urandom | $urandom);
          default: rx_pattern <= 16'($urandom & $urandom);
        endcase
      end else begin
        rx_phase <= rx_phase + 1;
      end
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    drive_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, drive %0d",
                                  $signed(out_tdata[DRIVE_W-1:0])));
      end else begin
        exp_r = expected_drives.pop_front();
        if (out_tdata[DRIVE_W-1:0] !== exp_r.drive)
          report_mismatch($sformatf("drive %0d, expected %0d",
                                    $signed(out_tdata[DRIVE_W-1:0]), exp_r.drive));
        if (out_tuser !== exp_r.saturated)
          report_mismatch($sformatf("drive_saturated %b, expected %b",
                                    out_tuser, exp_r.saturated));
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_derivative_on_measurement_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_gain_extremes();
    test_crossed_bounds();
    test_zero_sum();
    test_random_phases(8, 170);
    test_output_hold();
    test_full_rate();
    if (mismatch_count == 0) begin
      $display("pid_derivative_on_measurement_unit: match");
    end else begin
      $display("pid_derivative_on_measurement_unit: mismatch");
    end
    $finish;
  end

endmodule
